FILE: src/pfa_pkg.sv
// Package for the prime field ALU: operation codes, defaults and the
// status type of the modular multiplier. No dependencies.
package pfa_pkg;

    localparam int WIDTH_DEFAULT = 32;
    localparam int CMD_W = 3;
    localparam int MOD_RESET = 11;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEG = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INV = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

FILE: src/pfa_stream_if.sv
// Valid/ready stream interfaces for the prime field ALU input and result.
// Depends on pfa_pkg.
interface pfa_in_if #(parameter int WIDTH = pfa_pkg::WIDTH_DEFAULT);
    logic                        valid;
    logic                        ready;
    logic [pfa_pkg::CMD_W-1:0]   cmd;
    logic [WIDTH-1:0]            operand_a;
    logic [WIDTH-1:0]            operand_b;

    modport source (output valid, output cmd, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input cmd, input operand_a, input operand_b,
                  output ready);
endinterface

interface pfa_out_if #(parameter int WIDTH = pfa_pkg::WIDTH_DEFAULT);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

FILE: src/pfa_modmul.sv
// Bit-serial interleaved modular multiplier: x * y mod p, one bit of y a cycle.
// Requires x < p. Depends on pfa_pkg.
module pfa_modmul #(
    parameter int WIDTH = pfa_pkg::WIDTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WIDTH-1:0]    i_x,
    input  logic [WIDTH-1:0]    i_y,
    input  logic [WIDTH-1:0]    i_mod,
    output pfa_pkg::t_mm_status o_status,
    output logic [WIDTH-1:0]    o_result
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH+1:0] w_t;
    logic [WIDTH+1:0] w_p1;
    logic [WIDTH+1:0] w_p2;
    logic [WIDTH-1:0] w_next;

    always_comb begin
        w_p1 = {2'b00, i_mod};
        w_p2 = {1'b0, i_mod, 1'b0};
        w_t  = {1'b0, r_acc, 1'b0} + (r_y[WIDTH-1] ? {2'b00, r_x} : '0);
        if (w_t >= w_p2) begin
            w_next = WIDTH'(w_t - w_p2);
        end else if (w_t >= w_p1) begin
            w_next = WIDTH'(w_t - w_p1);
        end else begin
            w_next = WIDTH'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= w_next;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_acc;

endmodule

FILE: src/prime_field_alu_unit.sv
// Top level of the prime field ALU: sequencer, modulus register, output register.
// Depends on pfa_pkg, pfa_stream_if and pfa_modmul.
//
//  Channel   Direction  Signals                          Role
//  i_in      in         valid ready cmd operand_a/b      operation items
//  o_out     out        valid ready result               one result per item
//  i_cfg_*   in         i_cfg_we i_cfg_data              modulus register write
//
// All operations share one bit-serial modular multiplier. Operand reduction takes
// two passes; add, subtract and negate then finish without it, and multiply adds
// one pass. Inverse and divide add one pass per exponent bit plus one more per set
// bit; divide then adds one pass for the final product. A modulus below 2 gives a
// zero result, and a modulus of 2 skips the exponent passes.
// Reset is synchronous and sets the modulus to 11. The input is ready only while
// the sequencer is idle; a stalled result waits in the output register.
module prime_field_alu_unit #(
    parameter int WIDTH = pfa_pkg::WIDTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_data,
    pfa_in_if.sink           i_in,
    pfa_out_if.source        o_out
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RED_A   = 3'd1;
    localparam logic [2:0] S_RED_B   = 3'd2;
    localparam logic [2:0] S_EXEC    = 3'd3;
    localparam logic [2:0] S_EXP_MUL = 3'd4;
    localparam logic [2:0] S_EXP_SQR = 3'd5;
    localparam logic [2:0] S_MUL     = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]                r_state, n_state;
    logic                      r_issued, n_issued;
    logic [pfa_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [WIDTH-1:0]          r_a, n_a;
    logic [WIDTH-1:0]          r_b, n_b;
    logic [WIDTH-1:0]          r_acc, n_acc;
    logic [WIDTH-1:0]          r_base, n_base;
    logic [WIDTH-1:0]          r_exp, n_exp;
    logic [WIDTH-1:0]          r_res, n_res;
    logic [WIDTH-1:0]          r_mod;
    logic                      r_out_valid;
    logic [WIDTH-1:0]          r_out_result;

    logic                      w_in_xfer;
    logic                      w_out_free;
    logic                      w_mm_start;
    logic [WIDTH-1:0]          w_mm_x;
    logic [WIDTH-1:0]          w_mm_y;
    logic [WIDTH-1:0]          w_mm_res;
    pfa_pkg::t_mm_status       w_mm_sts;
    logic [WIDTH:0]            w_sum;
    logic [WIDTH:0]            w_dif;
    logic [WIDTH-1:0]          w_add_res;
    logic [WIDTH-1:0]          w_sub_res;
    logic [WIDTH-1:0]          w_one;
    logic                      w_mod_two;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_one      = WIDTH'(1);
    assign w_mod_two  = (r_mod == WIDTH'(2));

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_out_result;

    always_comb begin
        w_sum = {1'b0, r_a} + {1'b0, r_b};
        w_dif = {1'b0, r_a} + {1'b0, r_mod} - {1'b0, r_b};
        w_add_res = (w_sum >= {1'b0, r_mod}) ? WIDTH'(w_sum - {1'b0, r_mod}) : WIDTH'(w_sum);
        w_sub_res = (w_dif >= {1'b0, r_mod}) ? WIDTH'(w_dif - {1'b0, r_mod}) : WIDTH'(w_dif);
    end

    always_comb begin
        w_mm_x = w_one;
        w_mm_y = r_a;
        w_mm_start = 1'b0;
        case (r_state)
            S_RED_A: begin
                w_mm_x = w_one;
                w_mm_y = r_a;
                w_mm_start = !r_issued;
            end
            S_RED_B: begin
                w_mm_x = w_one;
                w_mm_y = r_b;
                w_mm_start = !r_issued;
            end
            S_EXP_MUL: begin
                w_mm_x = r_acc;
                w_mm_y = r_base;
                w_mm_start = !r_issued && r_exp[0];
            end
            S_EXP_SQR: begin
                w_mm_x = r_base;
                w_mm_y = r_base;
                w_mm_start = !r_issued;
            end
            S_MUL: begin
                w_mm_x = r_a;
                w_mm_y = r_b;
                w_mm_start = !r_issued;
            end
            default: begin
                w_mm_start = 1'b0;
            end
        endcase
    end

    pfa_modmul #(
        .WIDTH(WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mm_start),
        .i_x      (w_mm_x),
        .i_y      (w_mm_y),
        .i_mod    (r_mod),
        .o_status (w_mm_sts),
        .o_result (w_mm_res)
    );

    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_cmd    = r_cmd;
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        n_base   = r_base;
        n_exp    = r_exp;
        n_res    = r_res;
        if (w_mm_start) begin
            n_issued = 1'b1;
        end
        if (w_mm_sts.done) begin
            n_issued = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd = i_in.cmd;
                    n_a   = i_in.operand_a;
                    n_b   = i_in.operand_b;
                    if (r_mod < WIDTH'(2)) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RED_A;
                    end
                end
            end
            S_RED_A: begin
                if (w_mm_sts.done) begin
                    n_a     = w_mm_res;
                    n_state = S_RED_B;
                end
            end
            S_RED_B: begin
                if (w_mm_sts.done) begin
                    n_b     = w_mm_res;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_acc = w_one;
                n_exp = r_mod - WIDTH'(2);
                n_state = S_DONE;
                case (r_cmd)
                    pfa_pkg::CMD_ADD: begin
                        n_res = w_add_res;
                    end
                    pfa_pkg::CMD_SUB: begin
                        n_res = w_sub_res;
                    end
                    pfa_pkg::CMD_MUL: begin
                        n_state = S_MUL;
                    end
                    pfa_pkg::CMD_NEG: begin
                        n_res = (r_a != '0) ? r_mod - r_a : '0;
                    end
                    pfa_pkg::CMD_INV: begin
                        n_base = r_a;
                        if (w_mod_two) begin
                            n_res = r_a;
                        end else begin
                            n_state = S_EXP_MUL;
                        end
                    end
                    pfa_pkg::CMD_DIV: begin
                        n_base  = r_b;
                        n_state = w_mod_two ? S_MUL : S_EXP_MUL;
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_EXP_MUL: begin
                if (!r_exp[0]) begin
                    n_state = S_EXP_SQR;
                end else if (w_mm_sts.done) begin
                    n_acc   = w_mm_res;
                    n_state = S_EXP_SQR;
                end
            end
            S_EXP_SQR: begin
                if (w_mm_sts.done) begin
                    n_base = w_mm_res;
                    n_exp  = {1'b0, r_exp[WIDTH-1:1]};
                    if (r_exp[WIDTH-1:1] == '0) begin
                        if (r_cmd == pfa_pkg::CMD_INV) begin
                            n_res   = r_acc;
                            n_state = S_DONE;
                        end else begin
                            n_b     = r_acc;
                            n_state = S_MUL;
                        end
                    end else begin
                        n_state = S_EXP_MUL;
                    end
                end
            end
            S_MUL: begin
                if (w_mm_sts.done) begin
                    n_res   = w_mm_res;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_mod       <= WIDTH'(pfa_pkg::MOD_RESET);
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_res  <= n_res;
        if (r_state == S_DONE && w_out_free) begin
            r_out_result <= r_res;
        end
    end

endmodule
